// File: src/fwop_pkg.sv
// ----------------------------------------------------------------------------
// fwop_pkg: shared definitions for the FIFO with overflow policy
// Command, mode, status and action codes, register indexes, defaults and
// the flag bundle passed from the queue control to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package fwop_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int CMD_W    = 2;
	localparam int IO_WORD_W = 32;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] LIMIT_RESET = 9'd200;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] MODE_FLUSH = 2'd0;
	localparam logic [1:0] MODE_RING  = 2'd1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_DROP  = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE   = 1'b1;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] action;
		logic       pop_hit;
	} result_flags_t;

endpackage

`default_nettype wire

// File: src/fwop_mem.sv
// ----------------------------------------------------------------------------
// fwop_mem: word storage of the queue
// One write port and one read port with registered read data. The read
// register only loads on a read, so it holds while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fwop_mem #(
	parameter int CAPACITY   = 256,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [$clog2(CAPACITY)-1:0] waddr,
	input  wire logic [WORD_WIDTH-1:0]       wdata,
	input  wire logic                        re,
	input  wire logic [$clog2(CAPACITY)-1:0] raddr,
	output logic      [WORD_WIDTH-1:0]       rdata
);

	logic [WORD_WIDTH-1:0] mem_q [CAPACITY];
	logic [WORD_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/fwop_ctrl.sv
// ----------------------------------------------------------------------------
// fwop_ctrl: queue pointers, entry count and overflow policy
// Decodes one command per step, applies the policy at the depth limit and
// drives the storage write and read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module fwop_ctrl #(
	parameter int CAPACITY = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [fwop_pkg::CMD_W-1:0]    cmd,
	input  wire logic [fwop_pkg::CFG_W-1:0]    depth_limit,
	input  wire logic [1:0]                    fill_mode,
	output fwop_pkg::result_flags_t            flags,
	output logic      [$clog2(CAPACITY+1)-1:0] count_next,
	output logic                               mem_we,
	output logic      [$clog2(CAPACITY)-1:0]   mem_waddr,
	output logic                               mem_re,
	output logic      [$clog2(CAPACITY)-1:0]   mem_raddr
);

	import fwop_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [PTR_W-1:0] rd_ptr_n;
	logic [PTR_W-1:0] wr_ptr_n;
	logic [CNT_W-1:0] count_n;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] limit_cfg;
	logic             at_limit;
	logic             full;
	logic             nonempty;
	logic             store;
	logic             we_c;
	logic             re_c;
	result_flags_t    flags_c;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	// The limit in effect never exceeds the physical capacity.
	assign limit_cfg = CMP_W'(depth_limit);
	assign limit     = (limit_cfg > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : limit_cfg;
	assign at_limit  = CMP_W'(count_q) >= limit;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign nonempty  = count_q != '0;

	always_comb begin
		rd_ptr_n = rd_ptr_q;
		wr_ptr_n = wr_ptr_q;
		count_n  = count_q;
		store    = 1'b0;
		re_c     = 1'b0;
		flags_c  = '{status: ST_OK, action: ACT_NONE, pop_hit: 1'b0};

		unique case (cmd)
			CMD_PUSH: begin
				store = 1'b1;
				if (at_limit) begin
					case (fill_mode)
						MODE_FLUSH: begin
							if (nonempty) begin
								flags_c.action = ACT_FLUSH;
							end
							rd_ptr_n = wr_ptr_q;
							count_n  = '0;
						end
						MODE_RING: begin
							if (nonempty) begin
								flags_c.action = ACT_DROP;
								rd_ptr_n = next_ptr(rd_ptr_q);
								count_n  = count_q - 1'b1;
							end
						end
						default: begin
							if (full) begin
								flags_c.status = ST_REJECT;
								store = 1'b0;
							end
						end
					endcase
				end
				if (store) begin
					wr_ptr_n = next_ptr(wr_ptr_q);
					count_n  = count_n + 1'b1;
				end
			end
			CMD_POP: begin
				if (nonempty) begin
					re_c            = 1'b1;
					flags_c.pop_hit = 1'b1;
					rd_ptr_n        = next_ptr(rd_ptr_q);
					count_n         = count_q - 1'b1;
				end else begin
					flags_c.status = ST_EMPTY;
				end
			end
			CMD_FLUSH: begin
				rd_ptr_n = wr_ptr_q;
				count_n  = '0;
			end
			default: begin
			end
		endcase
	end

	assign we_c = store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else if (step) begin
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			count_q  <= count_n;
		end
	end

	assign flags      = flags_c;
	assign count_next = count_n;
	assign mem_we     = step & we_c;
	assign mem_waddr  = wr_ptr_q;
	assign mem_re     = step & re_c;
	assign mem_raddr  = rd_ptr_q;

endmodule

`default_nettype wire

// File: src/fifo_with_overflow_policy_core.sv
// ----------------------------------------------------------------------------
// fifo_with_overflow_policy_core: FIFO with depth limit and overflow policy
// Input register, queue control with word storage, and result register.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready with command (push, pop, flush) and
// push_word. Every request yields exactly one result on out_valid/out_ready
// with pop_word, status, overflow_action and depth_now (depth after the
// request). A push at the depth limit flushes, drops the oldest word, or
// grows up to CAPACITY depending on fill_mode.
// The request sits in the input register while control works out the new
// pointers, and the result register loads together with the storage read
// when it advances. One request is accepted every cycle while the result
// register is empty or being taken; the rate is set by the pointer update
// and the one-port storage read.
// When out_ready is low the result register holds, the input register holds
// behind it, and in_ready drops once both are full.
// Reset clears pointers, count and valid flags; depth_limit returns to 200
// and fill_mode to flush; storage is not cleared. The user must write the
// registers via cfg_we/cfg_index/cfg_data while idle; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_overflow_policy_core #(
	parameter int CAPACITY   = fwop_pkg::CAPACITY_DEF,
	parameter int WORD_WIDTH = fwop_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fwop_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fwop_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [fwop_pkg::CMD_W-1:0]        command,
	input  wire logic [fwop_pkg::IO_WORD_W-1:0]    push_word,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [fwop_pkg::IO_WORD_W-1:0]    pop_word,
	output logic      [1:0]                        status,
	output logic      [1:0]                        overflow_action,
	output logic      [$clog2(CAPACITY+1)-1:0]     depth_now
);

	import fwop_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CFG_W-1:0]      depth_limit_q;
	logic [1:0]            fill_mode_q;

	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [WORD_WIDTH-1:0] word_s1;

	logic                  valid_s2;
	result_flags_t         flags_s2;
	logic [CNT_W-1:0]      depth_s2;

	logic                  advance;
	logic                  step;
	result_flags_t         flags;
	logic [CNT_W-1:0]      count_next;
	logic                  mem_we;
	logic [PTR_W-1:0]      mem_waddr;
	logic                  mem_re;
	logic [PTR_W-1:0]      mem_raddr;
	logic [WORD_WIDTH-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= LIMIT_RESET;
			fill_mode_q   <= MODE_FLUSH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEPTH_LIMIT: depth_limit_q <= cfg_data;
				CFG_FILL_MODE:   fill_mode_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// The result register moves whenever it is empty or being taken.
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			word_s1 <= WORD_WIDTH'(push_word);
		end
	end

	fwop_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cmd         (cmd_s1),
		.depth_limit (depth_limit_q),
		.fill_mode   (fill_mode_q),
		.flags       (flags),
		.count_next  (count_next),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	fwop_mem #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (word_s1),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			flags_s2 <= flags;
			depth_s2 <= count_next;
		end
	end

	assign out_valid       = valid_s2;
	assign pop_word        = flags_s2.pop_hit ? IO_WORD_W'(rdata) : '0;
	assign status          = flags_s2.status;
	assign overflow_action = flags_s2.action;
	assign depth_now       = depth_s2;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the FIFO with overflow policy
// A queue of pending requests feeds a clocked driver; a clocked monitor
// predicts each accepted request with a behavioral copy of the queue and
// checks every result against the oldest prediction. The run steps through
// depth limits and fill modes, including zero, capacity and beyond.
// ----------------------------------------------------------------------------

module tb_top;
	import fwop_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int IDLE_LIMIT   = 1000;
	localparam int REPORT_LIMIT = 10;

	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;
	localparam logic [1:0]       MODE_GROW = 2'd2;
	localparam logic [1:0]       MODE_ALT  = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]     cmd;
		logic [IO_WORD_W-1:0] word;
	} fifo_request_t;

	typedef struct packed {
		logic [IO_WORD_W-1:0] pop_word;
		logic [1:0]           status;
		logic [1:0]           action;
		logic [8:0]           depth;
	} fifo_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [IO_WORD_W-1:0] push_word = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IO_WORD_W-1:0] pop_word;
	logic [1:0]           status;
	logic [1:0]           overflow_action;
	logic [8:0]           depth_now;

	fifo_with_overflow_policy_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.push_word       (push_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pop_word        (pop_word),
		.status          (status),
		.overflow_action (overflow_action),
		.depth_now       (depth_now)
	);

	// Behavioral copy of the queue and its registers.
	logic [IO_WORD_W-1:0] shadow_store [CAPACITY];
	int                   shadow_rd;
	int                   shadow_wr;
	int                   shadow_count;
	int                   shadow_limit;
	logic [1:0]           shadow_mode;

	fifo_request_t pending_requests[$];
	fifo_result_t  expected_results[$];
	fifo_request_t next_req;
	logic          in_taken = 1'b0;
	logic          steady = 1'b0;
	int            error_count = 0;
	int            idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic predict_queue(input logic [CMD_W-1:0] cmd, input logic [IO_WORD_W-1:0] word,
			output fifo_result_t res);
		int  eff_limit;
		bit  stored;
		eff_limit = (shadow_limit > CAPACITY) ? CAPACITY : shadow_limit;
		res = '0;
		stored = 1'b1;
		case (cmd)
			CMD_PUSH: begin
				if (shadow_count >= eff_limit) begin
					if (shadow_mode == MODE_FLUSH) begin
						if (shadow_count > 0)
							res.action = ACT_FLUSH;
						shadow_rd = shadow_wr;
						shadow_count = 0;
					end else if (shadow_mode == MODE_RING) begin
						if (shadow_count > 0) begin
							shadow_rd = (shadow_rd + 1) % CAPACITY;
							shadow_count--;
							res.action = ACT_DROP;
						end
					end else if (shadow_count >= CAPACITY) begin
						res.status = ST_REJECT;
						stored = 1'b0;
					end
				end
				if (stored) begin
					shadow_store[shadow_wr] = word;
					shadow_wr = (shadow_wr + 1) % CAPACITY;
					shadow_count++;
				end
			end
			CMD_POP: begin
				if (shadow_count > 0) begin
					res.pop_word = shadow_store[shadow_rd];
					shadow_rd = (shadow_rd + 1) % CAPACITY;
					shadow_count--;
				end else begin
					res.status = ST_EMPTY;
				end
			end
			CMD_FLUSH: begin
				shadow_rd = shadow_wr;
				shadow_count = 0;
			end
			default: ;
		endcase
		res.depth = shadow_count[8:0];
	endtask

	// Monitor: checks results, predicts accepted requests, runs the watchdog.
	always @(posedge clk) begin
		fifo_result_t got;
		fifo_result_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				got = {pop_word, status, overflow_action, depth_now};
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("unexpected result: pop_word %h status %0d action %0d depth %0d",
							got.pop_word, got.status, got.action, got.depth);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display("mismatch: expected pop_word %h status %0d action %0d depth %0d,",
								want.pop_word, want.status, want.action, want.depth,
								" got pop_word %h status %0d action %0d depth %0d",
								got.pop_word, got.status, got.action, got.depth);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_queue(command, push_word, want);
				expected_results.push_back(want);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Driver: offers the next request once the previous one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= 15);
			if (!in_valid || in_taken) begin
				if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
					next_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					command <= next_req.cmd;
					push_word <= next_req.word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [IO_WORD_W-1:0] word);
		fifo_request_t req;
		req.cmd = cmd;
		req.word = word;
		pending_requests.push_back(req);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_DEPTH_LIMIT)
			shadow_limit = int'(value);
		else
			shadow_mode = value[1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_policy(input int limit, input logic [1:0] mode);
		wait_drained();
		write_register(CFG_DEPTH_LIMIT, limit[CFG_W-1:0]);
		write_register(CFG_FILL_MODE, {7'd0, mode});
	endtask

	task automatic queue_random(input int n, input int push_pct, input int flush_pct);
		int                   r;
		logic [CMD_W-1:0]     cmd;
		logic [IO_WORD_W-1:0] word;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct)
				cmd = CMD_PUSH;
			else if (r < push_pct + flush_pct)
				cmd = CMD_FLUSH;
			else if (r < push_pct + flush_pct + 2)
				cmd = CMD_NOP;
			else
				cmd = CMD_POP;
			case ($urandom_range(0, 15))
				0: word = '0;
				1: word = '1;
				default: word = $urandom;
			endcase
			add_request(cmd, word);
		end
		wait_drained();
	endtask

	initial begin
		shadow_rd = 0;
		shadow_wr = 0;
		shadow_count = 0;
		shadow_limit = LIMIT_RESET;
		shadow_mode = MODE_FLUSH;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Defaults after reset: empty pops, no-op, extreme words.
		add_request(CMD_POP, 32'h0000_0000);
		add_request(CMD_NOP, 32'hDEAD_BEEF);
		add_request(CMD_FLUSH, 32'h1234_5678);
		add_request(CMD_PUSH, 32'h0000_0000);
		add_request(CMD_PUSH, 32'hFFFF_FFFF);
		add_request(CMD_POP, 32'h0);
		add_request(CMD_POP, 32'h0);
		add_request(CMD_POP, 32'h0);

		// A zero limit keeps at most one word; the first push finds the queue empty.
		set_policy(0, MODE_FLUSH);
		add_request(CMD_PUSH, 32'hA5A5_A5A5);
		add_request(CMD_PUSH, 32'h5A5A_5A5A);
		add_request(CMD_POP, 32'h0);
		set_policy(0, MODE_RING);
		add_request(CMD_PUSH, 32'h0F0F_0F0F);
		add_request(CMD_PUSH, 32'hF0F0_F0F0);
		add_request(CMD_POP, 32'h0);
		add_request(CMD_POP, 32'h0);

		// Lowering the limit below the count: ring drops one, flush empties.
		set_policy(200, MODE_FLUSH);
		add_request(CMD_PUSH, 32'h1111_1111);
		add_request(CMD_PUSH, 32'h2222_2222);
		add_request(CMD_PUSH, 32'h3333_3333);
		set_policy(1, MODE_RING);
		add_request(CMD_PUSH, 32'h4444_4444);
		set_policy(1, MODE_FLUSH);
		add_request(CMD_PUSH, 32'h5555_5555);
		set_policy(1, MODE_ALT);
		add_request(CMD_PUSH, 32'h6666_6666);
		add_request(CMD_PUSH, 32'h7777_7777);
		add_request(CMD_FLUSH, 32'h0);

		set_policy(1, MODE_FLUSH);
		queue_random(100, 60, 2);
		set_policy(2, MODE_RING);
		queue_random(100, 60, 2);
		set_policy(3, MODE_GROW);
		queue_random(100, 55, 2);
		set_policy(5, MODE_FLUSH);
		queue_random(120, 65, 2);
		set_policy(8, MODE_RING);
		queue_random(120, 65, 2);
		set_policy($urandom_range(1, 40), MODE_ALT);
		queue_random(120, 60, 2);

		// Grow to physical capacity and beyond; only the run at the capacity limit has no idling on either side.
		steady = 1'b1;
		set_policy(256, MODE_GROW);
		queue_random(330, 90, 0);
		steady = 1'b0;
		set_policy(511, MODE_RING);
		queue_random(320, 92, 0);
		set_policy(511, MODE_FLUSH);
		queue_random(300, 92, 0);
		set_policy(200, MODE_RING);
		queue_random(90, 50, 1);

		// The sender holds off here until every result has come back.
		set_policy($urandom_range(1, 256), 2'($urandom_range(0, 3)));
		queue_random(90, 55, 2);
		queue_random(90, 55, 2);
		set_policy(0, MODE_RING);
		queue_random(80, 50, 3);

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
